FILE: rtl/esd_pkg.sv
// Shared types for the escape string decoder.
// Used by esd_step and by the top level escape_string_decoder; no dependencies.
package esd_pkg;

  // Most decoded bytes that one input byte can give.
  localparam int unsigned RES_DEPTH = 3;

  typedef logic [7:0] byte_t;

  // Decoded bytes of one input transaction, lowest entry first.
  typedef struct packed {
    logic [1:0]                    cnt;
    logic                          last;
    logic [RES_DEPTH-1:0][7:0]     data;
  } res_t;

endpackage

FILE: rtl/esd_step.sv
// Decoder state and the per-byte decoding logic of the escape string decoder.
// Depends on esd_pkg for the result type.
module esd_step (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           acc,
  input  esd_pkg::byte_t byte_i,
  input  logic           last_i,
  output esd_pkg::res_t  res
);

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_HOLD_M,
    MODE_HOLD_C,
    MODE_ESCAPE,
    MODE_CARET,
    MODE_OCTAL
  } mode_t;

  localparam esd_pkg::byte_t CH_ESC   = 8'h1B;
  localparam esd_pkg::byte_t CH_CR    = 8'h0D;
  localparam esd_pkg::byte_t CH_BEL   = 8'h07;
  localparam esd_pkg::byte_t CH_LF    = 8'h0A;
  localparam esd_pkg::byte_t CH_TAB   = 8'h09;
  localparam esd_pkg::byte_t CH_BS    = 8'h08;
  localparam esd_pkg::byte_t CH_FF    = 8'h0C;
  localparam esd_pkg::byte_t CH_VT    = 8'h0B;
  localparam esd_pkg::byte_t CH_DEL   = 8'h7F;
  localparam esd_pkg::byte_t CH_SPACE = 8'h20;
  localparam esd_pkg::byte_t CH_DASH  = 8'h2D;
  localparam esd_pkg::byte_t CH_BSL   = 8'h5C;
  localparam esd_pkg::byte_t CH_CARET = 8'h5E;
  localparam esd_pkg::byte_t CH_QUEST = 8'h3F;
  localparam esd_pkg::byte_t CH_RBRK  = 8'h5D;
  localparam esd_pkg::byte_t CH_ZERO  = 8'h30;
  localparam esd_pkg::byte_t CH_SEVEN = 8'h37;
  localparam esd_pkg::byte_t LC_A     = 8'h61;
  localparam esd_pkg::byte_t LC_B     = 8'h62;
  localparam esd_pkg::byte_t LC_C     = 8'h63;
  localparam esd_pkg::byte_t LC_E     = 8'h65;
  localparam esd_pkg::byte_t LC_F     = 8'h66;
  localparam esd_pkg::byte_t LC_M     = 8'h6D;
  localparam esd_pkg::byte_t LC_N     = 8'h6E;
  localparam esd_pkg::byte_t LC_R     = 8'h72;
  localparam esd_pkg::byte_t LC_T     = 8'h74;
  localparam esd_pkg::byte_t LC_V     = 8'h76;
  localparam esd_pkg::byte_t LC_X     = 8'h78;

  // Results gathered so far in this transaction, plus the record of the
  // first, second and latest decoded bytes of the string.
  typedef struct packed {
    logic [1:0]                              n;
    logic [esd_pkg::RES_DEPTH-1:0][7:0]      data;
    logic [1:0]                              ecnt;
    esd_pkg::byte_t                          first;
    esd_pkg::byte_t                          second;
    esd_pkg::byte_t                          lastb;
  } trk_t;

  function automatic esd_pkg::byte_t lower_of(esd_pkg::byte_t c);
    lower_of = (c >= 8'h41 && c <= 8'h5A) ? (c + 8'h20) : c;
  endfunction

  // Upper-casing only touches bit 5, so the low five bits are the code.
  function automatic esd_pkg::byte_t ctrl_of(esd_pkg::byte_t c);
    ctrl_of = (c == CH_QUEST) ? CH_DEL : {3'b000, c[4:0]};
  endfunction

  function automatic trk_t emit_byte(trk_t t, esd_pkg::byte_t b);
    trk_t r;
    r = t;
    if (r.n < 2'(esd_pkg::RES_DEPTH)) begin
      r.data[r.n] = b;
      r.n = r.n + 2'd1;
      if (r.ecnt == 2'd0) begin
        r.first = b;
      end else if (r.ecnt == 2'd1) begin
        r.second = b;
      end
      if (r.ecnt < 2'd2) begin
        r.ecnt = r.ecnt + 2'd1;
      end
      r.lastb = b;
    end
    return r;
  endfunction

  mode_t          mode_r, mode_nxt;
  esd_pkg::byte_t held_r, held_nxt;
  esd_pkg::byte_t prev_r;
  esd_pkg::byte_t oct_r, oct_nxt;
  logic           start_r, start_nxt;
  logic [1:0]     ecnt_r;
  esd_pkg::byte_t first_r, second_r, lastb_r;

  trk_t           t;
  logic           do_fresh;
  esd_pkg::byte_t fprev;
  logic           qual;
  logic           is_oct;
  esd_pkg::byte_t lb;

  assign is_oct = (byte_i >= CH_ZERO) && (byte_i <= CH_SEVEN);
  assign lb     = lower_of(byte_i);

  always_comb begin
    t          = '0;
    t.ecnt     = ecnt_r;
    t.first    = first_r;
    t.second   = second_r;
    t.lastb    = lastb_r;
    mode_nxt   = mode_r;
    held_nxt   = held_r;
    oct_nxt    = oct_r;
    start_nxt  = start_r;
    do_fresh   = 1'b0;
    fprev      = prev_r;
    qual       = 1'b0;

    case (mode_r)
      MODE_HOLD_M: begin
        if (byte_i == CH_DASH) begin
          mode_nxt = MODE_NORMAL;
          t = emit_byte(t, CH_ESC);
        end else begin
          t = emit_byte(t, held_r);
          fprev = held_r;
          do_fresh = 1'b1;
        end
      end
      MODE_HOLD_C: begin
        if (byte_i == CH_DASH) begin
          mode_nxt = last_i ? MODE_NORMAL : MODE_CARET;
        end else begin
          t = emit_byte(t, held_r);
          fprev = held_r;
          do_fresh = 1'b1;
        end
      end
      MODE_ESCAPE: begin
        mode_nxt = MODE_NORMAL;
        if (is_oct) begin
          oct_nxt = {5'd0, byte_i[2:0]};
          if (last_i) begin
            t = emit_byte(t, oct_nxt);
          end else begin
            mode_nxt = MODE_OCTAL;
          end
        end else begin
          case (lb)
            LC_N:    t = emit_byte(t, CH_LF);
            LC_R:    t = emit_byte(t, CH_CR);
            LC_T:    t = emit_byte(t, CH_TAB);
            LC_B:    t = emit_byte(t, CH_BS);
            LC_F:    t = emit_byte(t, CH_FF);
            LC_A:    t = emit_byte(t, CH_BEL);
            LC_V:    t = emit_byte(t, CH_VT);
            LC_E:    t = emit_byte(t, CH_ESC);
            LC_C: begin
              if (!last_i) begin
                mode_nxt = MODE_CARET;
              end
            end
            default: t = emit_byte(t, byte_i);
          endcase
        end
      end
      MODE_CARET: begin
        mode_nxt = MODE_NORMAL;
        t = emit_byte(t, ctrl_of(byte_i));
      end
      MODE_OCTAL: begin
        if (is_oct) begin
          // Multiplying by eight modulo 256 is a shift that drops the top bits.
          oct_nxt = {oct_r[4:0], byte_i[2:0]};
          if (last_i) begin
            mode_nxt = MODE_NORMAL;
            t = emit_byte(t, oct_nxt);
          end
        end else begin
          mode_nxt = MODE_NORMAL;
          t = emit_byte(t, oct_r);
          do_fresh = 1'b1;
        end
      end
      default: begin
        do_fresh = 1'b1;
      end
    endcase

    if (do_fresh) begin
      qual = start_r || (fprev == CH_SPACE) || (fprev < CH_SPACE) || (fprev >= CH_DEL);
      start_nxt = 1'b0;
      mode_nxt  = MODE_NORMAL;
      if (lb == LC_M && qual && !last_i) begin
        held_nxt = byte_i;
        mode_nxt = MODE_HOLD_M;
      end else if (lb == LC_C && !last_i) begin
        held_nxt = byte_i;
        mode_nxt = MODE_HOLD_C;
      end else if (byte_i == CH_BSL) begin
        if (!last_i) begin
          mode_nxt = MODE_ESCAPE;
        end
      end else if (byte_i == CH_CARET) begin
        if (!last_i) begin
          mode_nxt = MODE_CARET;
        end
      end else begin
        t = emit_byte(t, byte_i);
      end
    end

    // Terminal fix-ups for strings that open with ESC x or ESC ].
    if (last_i) begin
      if (t.ecnt == 2'd2 && t.first == CH_ESC && lower_of(t.second) == LC_X &&
          t.lastb != CH_CR) begin
        t = emit_byte(t, CH_CR);
      end else if (t.ecnt == 2'd2 && t.first == CH_ESC && t.second == CH_RBRK &&
                   t.lastb != CH_BEL) begin
        t = emit_byte(t, CH_BEL);
      end
    end

    res.cnt  = t.n;
    res.data = t.data;
    res.last = last_i && (t.n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && last_i)) begin
      mode_r   <= MODE_NORMAL;
      held_r   <= '0;
      prev_r   <= '0;
      oct_r    <= '0;
      start_r  <= 1'b1;
      ecnt_r   <= '0;
      first_r  <= '0;
      second_r <= '0;
      lastb_r  <= '0;
    end else if (acc) begin
      mode_r   <= mode_nxt;
      held_r   <= held_nxt;
      prev_r   <= byte_i;
      oct_r    <= oct_nxt;
      start_r  <= start_nxt;
      ecnt_r   <= t.ecnt;
      first_r  <= t.first;
      second_r <= t.second;
      lastb_r  <= t.lastb;
    end
  end

endmodule

FILE: rtl/escape_string_decoder.sv
// Output: the first decoded byte of a transaction is offered in the cycle after acceptance.
// Throughput: one input byte per cycle while each byte gives at most one decoded byte and the
// receiver is ready; a byte that gives k decoded bytes (k <= 3) holds off new input until its last one leaves.
// Reset: rst_n is synchronous and active low; it returns the decoder to the start of a
// string and empties the result buffer.
module escape_string_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // in_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast   // out_last
);

  esd_pkg::res_t res;
  logic          in_hs, out_hs;

  logic [esd_pkg::RES_DEPTH-1:0][7:0] buf_r;
  logic [1:0]                         cnt_r;
  logic [1:0]                         idx_r;
  logic                               last_r;

  assign in_hs  = in_tvalid && in_tready;
  assign out_hs = out_tvalid && out_tready;

  // A new transaction may enter once the buffer is empty or its final byte leaves now.
  assign in_tready = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_tready);

  esd_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (in_hs),
    .byte_i (in_tdata),
    .last_i (in_tlast),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      idx_r  <= '0;
      last_r <= 1'b0;
    end else if (in_hs && res.cnt != 2'd0) begin
      cnt_r  <= res.cnt;
      idx_r  <= '0;
      last_r <= res.last;
    end else if (out_hs) begin
      cnt_r  <= cnt_r - 2'd1;
      idx_r  <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_hs && res.cnt != 2'd0) begin
      buf_r <= res.data;
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = buf_r[idx_r];
  assign out_tlast  = last_r && (cnt_r == 2'd1);

`ifndef ASSERT_OFF
  a_result_offered: assert property (@(posedge clk) disable iff (!rst_n)
    (in_hs && res.cnt != 2'd0) |=> out_tvalid)
    else $error("decoded bytes of an accepted transaction were not offered");

  a_buffer_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, idx_r} + {1'b0, cnt_r}) <= 3'(esd_pkg::RES_DEPTH))
    else $error("result buffer read position runs past its entries");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r > 2'd1) |-> !in_tready)
    else $error("input accepted while undelivered decoded bytes remain");
`endif

endmodule

FILE: tb/esd_decode_checker.sv
`timescale 1ns / 1ps
// Checker for the escape string decoder: watches both stream channels, predicts the decoded
// bytes of every accepted input byte and compares them in order. Depends on esd_pkg.
module esd_decode_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // in_last
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [7:0] out_byte
  input  logic       out_tlast,  // out_last
  output int         fail_count,
  output int         open_count
);

  localparam esd_pkg::byte_t CH_ESC = 8'h1B;
  localparam esd_pkg::byte_t CH_CR  = 8'h0D;
  localparam esd_pkg::byte_t CH_BEL = 8'h07;

  typedef enum logic [2:0] {
    ST_NORMAL, ST_HOLD_M, ST_HOLD_C, ST_ESCAPE, ST_CARET, ST_OCTAL
  } dec_mode_t;

  typedef struct packed {
    esd_pkg::byte_t data;
    logic           last;
  } dec_out_t;

  dec_mode_t      mode;
  esd_pkg::byte_t held_b;
  esd_pkg::byte_t prev_b;
  esd_pkg::byte_t oct_v;
  bit             at_start;
  int             emit_cnt;
  esd_pkg::byte_t first_b;
  esd_pkg::byte_t second_b;
  esd_pkg::byte_t last_b;

  esd_pkg::byte_t step_q[$];
  dec_out_t       decoded_q[$];

  function automatic esd_pkg::byte_t fold_lower(esd_pkg::byte_t c);
    return (c >= "A" && c <= "Z") ? esd_pkg::byte_t'(c + 8'd32) : c;
  endfunction

  function automatic esd_pkg::byte_t ctrl_code(esd_pkg::byte_t c);
    esd_pkg::byte_t u;
    if (c == "?") return 8'h7F;
    u = (c >= "a" && c <= "z") ? esd_pkg::byte_t'(c - 8'd32) : c;
    return u & 8'h1F;
  endfunction

  task automatic clear_decoder();
    mode     = ST_NORMAL;
    held_b   = '0;
    prev_b   = '0;
    oct_v    = '0;
    at_start = 1'b1;
    emit_cnt = 0;
    first_b  = '0;
    second_b = '0;
    last_b   = '0;
  endtask

  // Anything beyond the third byte of one transaction is lost, as in the block.
  task automatic emit_decoded(esd_pkg::byte_t b);
    if (step_q.size() < esd_pkg::RES_DEPTH) begin
      step_q.push_back(b);
      if (emit_cnt == 0) first_b = b;
      else if (emit_cnt == 1) second_b = b;
      if (emit_cnt < 2) emit_cnt++;
      last_b = b;
    end
  endtask

  task automatic begin_unit(esd_pkg::byte_t b, bit fin);
    bit qual;
    qual = at_start || prev_b == " " || prev_b < 8'h20 || prev_b >= 8'h7F;
    at_start = 1'b0;
    mode = ST_NORMAL;
    if (fold_lower(b) == "m" && qual && !fin) begin
      held_b = b;
      mode = ST_HOLD_M;
    end else if (fold_lower(b) == "c" && !fin) begin
      held_b = b;
      mode = ST_HOLD_C;
    end else if (b == "\\") begin
      if (!fin) mode = ST_ESCAPE;
    end else if (b == "^") begin
      if (!fin) mode = ST_CARET;
    end else begin
      emit_decoded(b);
    end
  endtask

  task automatic decode_in_byte(esd_pkg::byte_t b, bit fin);
    dec_out_t item;
    step_q.delete();
    case (mode)
      ST_HOLD_M, ST_HOLD_C: begin
        if (b == "-") begin
          if (mode == ST_HOLD_M) begin
            mode = ST_NORMAL;
            emit_decoded(CH_ESC);
          end else begin
            mode = fin ? ST_NORMAL : ST_CARET;
          end
        end else begin
          emit_decoded(held_b);
          prev_b = held_b;
          begin_unit(b, fin);
        end
      end
      ST_ESCAPE: begin
        mode = ST_NORMAL;
        if (b >= "0" && b <= "7") begin
          oct_v = esd_pkg::byte_t'(b - "0");
          if (fin) emit_decoded(oct_v);
          else mode = ST_OCTAL;
        end else begin
          case (fold_lower(b))
            "n":     emit_decoded(8'h0A);
            "r":     emit_decoded(8'h0D);
            "t":     emit_decoded(8'h09);
            "b":     emit_decoded(8'h08);
            "f":     emit_decoded(8'h0C);
            "a":     emit_decoded(8'h07);
            "v":     emit_decoded(8'h0B);
            "e":     emit_decoded(CH_ESC);
            "c":     if (!fin) mode = ST_CARET;
            default: emit_decoded(b);
          endcase
        end
      end
      ST_CARET: begin
        mode = ST_NORMAL;
        emit_decoded(ctrl_code(b));
      end
      ST_OCTAL: begin
        if (b >= "0" && b <= "7") begin
          oct_v = esd_pkg::byte_t'(oct_v * 8 + (b - "0"));
          if (fin) begin
            mode = ST_NORMAL;
            emit_decoded(oct_v);
          end
        end else begin
          mode = ST_NORMAL;
          emit_decoded(oct_v);
          begin_unit(b, fin);
        end
      end
      default: begin_unit(b, fin);
    endcase
    prev_b = b;

    if (fin) begin
      // A decoded string that opens with ESC x or ESC ] gets its terminator.
      if (emit_cnt == 2 && first_b == CH_ESC && fold_lower(second_b) == "x" &&
          last_b != CH_CR)
        emit_decoded(CH_CR);
      else if (emit_cnt == 2 && first_b == CH_ESC && second_b == "]" && last_b != CH_BEL)
        emit_decoded(CH_BEL);
      clear_decoder();
    end

    foreach (step_q[i]) begin
      item.data = step_q[i];
      item.last = fin && (i == step_q.size() - 1);
      decoded_q.push_back(item);
    end
  endtask

  always @(posedge clk) begin
    dec_out_t want;
    if (!rst_n) begin
      clear_decoder();
      decoded_q.delete();
      fail_count = 0;
    end else begin
      if (in_tvalid && in_tready) decode_in_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected transaction: expected none, actual byte %02h last %0b",
                   $time, out_tdata, out_tlast);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          if (out_tdata !== want.data) begin
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, want.data, out_tdata);
            fail_count++;
          end
          if (out_tlast !== want.last) begin
            $display("%0t: out_last mismatch: expected %0b, actual %0b",
                     $time, want.last, out_tlast);
            fail_count++;
          end
        end
      end
    end
    open_count = decoded_q.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the escape string decoder testbench: clock, reset, byte stimulus and receiver
// back-pressure; depends on escape_string_decoder, esd_decode_checker and esd_pkg.
module tb_top;

  localparam int HOLD_CYCLES = 64;
  localparam int DIRECTED_ITEMS = 25;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] in_byte
  logic       in_tlast;   // in_last
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] out_byte
  logic       out_tlast;  // out_last

  int             fail_count;
  int             open_count;
  int             bytes_sent;
  bit             idle_on;
  bit             hold_req;
  esd_pkg::byte_t word_q[$];

  escape_string_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  esd_decode_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: one long hold-off on request, otherwise short random stalls while idle_on is set.
  initial begin
    out_tready = 1'b0;
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(esd_pkg::byte_t b, bit fin);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic push_text(string s);
    foreach (s[i]) word_q.push_back(esd_pkg::byte_t'(s[i]));
  endtask

  task automatic send_word();
    foreach (word_q[i]) send_item(word_q[i], i == word_q.size() - 1);
    word_q.delete();
  endtask

  task automatic send_text(string s);
    push_text(s);
    send_word();
  endtask

  // Holds the input quiet until every predicted byte has come out.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (open_count != 0);
    @(posedge clk);
  endtask

  task automatic add_unit();
    string esc_letters;
    int    n;
    esc_letters = "nrtbfaveNRTBFAVE";
    case ($urandom_range(0, 11))
      0, 1: word_q.push_back(esd_pkg::byte_t'($urandom_range(0, 255)));
      2: begin
        word_q.push_back("\\");
        word_q.push_back(esd_pkg::byte_t'(esc_letters[$urandom_range(0, 15)]));
      end
      3: begin
        word_q.push_back("\\");
        word_q.push_back(esd_pkg::byte_t'($urandom_range(0, 255)));
      end
      4: begin
        word_q.push_back("\\");
        n = $urandom_range(1, 4);
        repeat (n) word_q.push_back(esd_pkg::byte_t'("0" + $urandom_range(0, 7)));
      end
      5: begin
        push_text($urandom_range(0, 1) ? "\\c" : "\\C");
        word_q.push_back(esd_pkg::byte_t'($urandom_range(0, 255)));
      end
      6: begin
        word_q.push_back("^");
        word_q.push_back($urandom_range(0, 3) == 0 ? esd_pkg::byte_t'("?")
          : esd_pkg::byte_t'($urandom_range(0, 255)));
      end
      7: begin
        push_text($urandom_range(0, 1) ? "C-" : "c-");
        word_q.push_back(esd_pkg::byte_t'($urandom_range(0, 255)));
      end
      8: begin
        push_text($urandom_range(0, 1) ? "M-" : "m-");
        word_q.push_back(esd_pkg::byte_t'($urandom_range(0, 255)));
      end
      9: begin
        case ($urandom_range(0, 3))
          0: push_text("M");
          1: push_text("m");
          2: push_text("C");
          default: push_text("c");
        endcase
        word_q.push_back(esd_pkg::byte_t'($urandom_range(0, 255)));
      end
      10: push_text(" ");
      default: word_q.push_back(esd_pkg::byte_t'($urandom_range(8'h20, 8'h7E)));
    endcase
  endtask

  // A string of random escape units; some open with ESC x or ESC ], some end already
  // terminated, and some end in an unfinished escape or a lone M or C.
  task automatic send_random_string();
    int n_units;
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 4))
        0: push_text("M-x");
        1: push_text("m-X");
        2: push_text("\\ex");
        3: push_text("\\e]");
        default: push_text("^[]");
      endcase
    end
    n_units = $urandom_range(0, 5);
    repeat (n_units) add_unit();
    case ($urandom_range(0, 11))
      0: push_text("\\r");
      1: push_text("^G");
      2: push_text("\\a");
      3: push_text("\\");
      4: push_text("^");
      5: push_text("C-");
      6: push_text("\\c");
      7: push_text($urandom_range(0, 1) ? "M" : "c");
      default: ;
    endcase
    if (word_q.size() == 0) add_unit();
    send_word();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    bytes_sent = 0;
    idle_on    = 1'b1;
    hold_req   = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
    send_text("M-x");
    send_text("\\e]0");
    send_text("\\101");
    send_text("^?");
    send_text("C-a");
    send_text("a\\");
    send_text("m");
    send_text("Mq");
    send_text("\\N");
    wait_for_drain();

    // The receiver stalls for a long stretch while strings keep coming.
    hold_req = 1'b1;
    while (bytes_sent < DIRECTED_ITEMS + 45) send_random_string();
    wait_for_drain();
    while (bytes_sent < DIRECTED_ITEMS + 90) send_random_string();
    idle_on = 1'b0;
    while (bytes_sent < DIRECTED_ITEMS + 130) send_random_string();

    wait_for_drain();
    repeat (20) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && open_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
